// ===== hdl/slr_pkg.sv =====
// Shared types and constants for the streaming literal replace core.
package slr_pkg;

    localparam int JOB_BYTES   = 8;   // widest pattern or replacement
    localparam int QUEUE_DEPTH = 4;   // job queue between front and back

    localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } t_cfg;

    // One job: the bytes that one input item releases, oldest in entry 0.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [3:0]                count;   // 0 with fin set: empty end marker
        logic                      fin;     // job closes the string
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== hdl/stream_literal_replace_core.sv =====
// Top level of the streaming literal replace core.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+----------------------------------
//  input   | in        | i_in_valid / o_in_stall      | i_in_byte, i_in_final
//  output  | out       | o_out_valid / i_out_stall    | o_out_byte, o_byte_present,
//          |           |                              | o_run_end, o_string_end
//  config  | in        | i_cfg_we (no handshake back) | i_cfg_index, i_cfg_data
//
// One input item is taken per cycle while the job queue has room; the front
// compares the window with the pattern in the same cycle and queues any job.
// The back sends one result item per cycle while the output is not stalled, so
// an item yields its 0 to 8 results in turn; expansions fill the queue and stall
// the input. Output stall holds the current result; input stall rises when the
// queue is full. Reset is synchronous, active low; it empties window, queue and
// back end and clears the config registers. No clearing pass is needed.
module stream_literal_replace_core #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_final,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_present,
    output logic        o_run_end,
    output logic        o_string_end
);

    // config registers; the user must write them only while the core is idle, the core does not enforce this
    slr_pkg::t_cfg   r_cfg;

    logic            push;
    logic            pop;
    slr_pkg::t_job   job_in;
    slr_pkg::t_job   job_head;
    slr_pkg::t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slr_pkg::CFG_PATTERN_BYTES:      r_cfg.pattern_bytes      <= i_cfg_data;
                slr_pkg::CFG_PATTERN_LENGTH:     r_cfg.pattern_length     <= i_cfg_data[3:0];
                slr_pkg::CFG_REPLACEMENT_BYTES:  r_cfg.replacement_bytes  <= i_cfg_data;
                slr_pkg::CFG_REPLACEMENT_LENGTH: r_cfg.replacement_length <= i_cfg_data[3:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: window, match test, job build
    slr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_in_final (i_in_final),
        .o_stall    (o_in_stall),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (job_in)
    );

    // decouples the two sides
    slr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_qstat (qstat)
    );

    // back: one result item per cycle while the output is not stalled
    slr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (job_head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_end      (o_run_end),
        .o_string_end   (o_string_end)
    );

endmodule

// ===== hdl/slr_front.sv =====
// Front end: window of waiting bytes, pattern compare, job build.
module slr_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  slr_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_final,
    output logic          o_stall,
    input  slr_pkg::t_qstat i_qstat,
    output logic          o_push,
    output slr_pkg::t_job o_job
);

    localparam int PW = $clog2(MAX_PATTERN + 1);

    logic [7:0]    r_win [MAX_PATTERN];
    logic [7:0]    n_win [MAX_PATTERN];
    logic [PW-1:0] r_pend;
    logic [PW-1:0] n_pend;

    logic [7:0]    win_app [MAX_PATTERN];
    logic [PW-1:0] pend_app;
    logic          room;
    logic          accept;
    logic [3:0]    plen;
    logic [3:0]    rlen;
    logic [3:0]    pend4;
    logic          equal;
    logic          match;
    logic          emit_one;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    assign plen = (i_cfg.pattern_length > 4'(MAX_PATTERN)) ?
                  4'(MAX_PATTERN) : i_cfg.pattern_length;
    assign rlen = (i_cfg.replacement_length > 4'(MAX_REPLACEMENT)) ?
                  4'(MAX_REPLACEMENT) : i_cfg.replacement_length;

    // window with the new byte appended
    assign room     = r_pend < PW'(MAX_PATTERN);
    assign pend_app = r_pend + PW'(room);
    assign pend4    = 4'(pend_app);

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_app[i] = (room && r_pend == PW'(i)) ? i_in_byte : r_win[i];
        end
    end

    always_comb begin
        equal = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (4'(i) < plen && win_app[i] != i_cfg.pattern_bytes[8*i +: 8]) begin
                equal = 1'b0;
            end
        end
    end

    assign match    = (plen != 4'd0) && (pend4 == plen) && equal;
    assign emit_one = (pend4 >= plen) && (pend4 != 4'd0);

    always_comb begin
        o_job     = '0;
        o_job.fin = i_in_final;
        if (match) begin
            o_job.data  = i_cfg.replacement_bytes;
            o_job.count = rlen;
        end else begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                o_job.data[i] = win_app[i];
            end
            o_job.count = i_in_final ? pend4 : {3'b000, emit_one};
        end
    end

    assign o_push = accept && (o_job.count != 4'd0 || i_in_final);

    always_comb begin
        n_win  = r_win;
        n_pend = r_pend;
        if (accept) begin
            if (match || i_in_final) begin
                n_pend = '0;
            end else if (emit_one) begin
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    n_win[i] = win_app[i+1];
                end
                n_win[MAX_PATTERN-1] = 8'h00;
                n_pend = pend_app - PW'(1);
            end else begin
                n_win  = win_app;
                n_pend = pend_app;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
        r_win <= n_win;
    end

endmodule

// ===== hdl/slr_queue.sv =====
// Small job queue between front and back.
module slr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slr_pkg::t_job   i_job,
    input  logic            i_pop,
    output slr_pkg::t_job   o_head,
    output slr_pkg::t_qstat o_qstat
);

    localparam int AW = $clog2(slr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(slr_pkg::QUEUE_DEPTH + 1);

    slr_pkg::t_job r_mem [slr_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == CW'(slr_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < CW'(slr_pkg::QUEUE_DEPTH) || i_pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("job queue underflow");
`endif

endmodule

// ===== hdl/slr_back.sv =====
// Back end: plays out each job one result item per cycle while the output is not stalled.
module slr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slr_pkg::t_job   i_head,
    input  slr_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_present,
    output logic            o_run_end,
    output logic            o_string_end
);

    logic          r_busy;
    slr_pkg::t_job r_job;
    logic [2:0]    r_idx;

    logic last;
    logic advance;

    assign last    = (r_job.count == 4'd0) || ({1'b0, r_idx} == r_job.count - 4'd1);
    assign advance = r_busy && !i_stall;
    assign o_pop   = (!r_busy || (advance && last)) && !i_qstat.empty;

    assign o_valid        = r_busy;
    assign o_byte_present = (r_job.count != 4'd0);
    assign o_out_byte     = o_byte_present ? r_job.data[r_idx] : 8'h00;
    assign o_run_end      = last;
    assign o_string_end   = last && r_job.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (advance) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
        if (o_pop) begin
            r_job <= i_head;
        end
    end

`ifndef NO_ASSERTIONS
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_present) |-> (o_run_end && o_string_end))
        else $error("empty marker not closing the string");
    a_string_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_end) |-> o_run_end)
        else $error("string end without run end");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.count != 4'd0) |-> ({1'b0, r_idx} < r_job.count))
        else $error("result index past job count");
`endif

endmodule
